// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the tile fetcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ----- design/bgwtf_pkg.sv -----
// ----------------------------------------------------------------------------
// bgwtf_pkg
// Types, codes and constants shared by the tile fetcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bgwtf_pkg;

  // Default pixel FIFO threshold for the push phase
  localparam int FIFO_LIMIT_DEF = 16;

  // Map and tile data bases
  localparam logic [15:0] MAP_BASE_LO   = 16'h9800;
  localparam logic [15:0] MAP_BASE_HI   = 16'h9C00;
  localparam logic [15:0] TILE_BASE_UNS = 16'h8000;
  localparam logic [15:0] TILE_BASE_SGN = 16'h9000;

  // Pixels per tile row
  localparam int TILE_PIXELS = 8;
  localparam int PIX_CNT_W   = $clog2(TILE_PIXELS);

  // Result kinds
  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MODE     = 3'd0,
    CFG_SCROLL_X = 3'd1,
    CFG_SCROLL_Y = 3'd2,
    CFG_WINDOW_X = 3'd3,
    CFG_WINDOW_Y = 3'd4
  } cfg_idx_e;

  // Mode flag bit positions
  localparam int MODE_BG_EN     = 0;
  localparam int MODE_BG_MAP    = 1;
  localparam int MODE_WIN_MAP   = 2;
  localparam int MODE_UNS_TILES = 3;
  localparam int MODE_WIN_EN    = 4;

  // Fetch sequencer phases
  typedef enum logic [4:0] {
    PH_MAP   = 5'b00001,
    PH_INDEX = 5'b00010,
    PH_LOW   = 5'b00100,
    PH_HIGH  = 5'b01000,
    PH_PUSH  = 5'b10000
  } phase_e;

  // Input beat
  typedef struct packed {
    logic       req_type;
    logic [7:0] read_data;
    logic [7:0] line_y;
    logic [7:0] window_line;
    logic [4:0] fifo_fill;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] mem_addr;
    logic [1:0]  pixel_color;
    logic        last;
  } out_t;

  // Configuration registers
  typedef struct packed {
    logic [4:0] mode_flags;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
  } cfg_t;

  // Result descriptor from the sequencer to the output stage
  typedef struct packed {
    logic        valid;
    logic        pixels;
    kind_e       kind;
    logic [15:0] addr;
    logic [7:0]  low;
    logic [7:0]  high;
  } burst_t;

endpackage

`default_nettype wire

// ----- design/bgwtf_cfg.sv -----
// ----------------------------------------------------------------------------
// bgwtf_cfg
// Configuration register file written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bgwtf_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [2:0]     cfg_index_i,
  input  wire logic [7:0]     cfg_data_i,
  output bgwtf_pkg::cfg_t     cfg_o
);
  import bgwtf_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:     cfg_d.mode_flags = cfg_data_i[4:0];
        CFG_SCROLL_X: cfg_d.scroll_x   = cfg_data_i;
        CFG_SCROLL_Y: cfg_d.scroll_y   = cfg_data_i;
        CFG_WINDOW_X: cfg_d.window_x   = cfg_data_i;
        CFG_WINDOW_Y: cfg_d.window_y   = cfg_data_i;
        default:      cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- design/bgwtf_seq.sv -----
// ----------------------------------------------------------------------------
// bgwtf_seq
// Five-phase fetch sequencer: map read, tile row address, plane capture, push.
// ----------------------------------------------------------------------------
`default_nettype none

module bgwtf_seq #(
  parameter int FIFO_LIMIT = bgwtf_pkg::FIFO_LIMIT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire bgwtf_pkg::in_t  in_i,
  input  wire bgwtf_pkg::cfg_t cfg_i,
  output bgwtf_pkg::burst_t    burst_o
);
  import bgwtf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  high_q, high_d;

  logic        win_sel;
  logic [4:0]  map_col, map_row;
  logic [15:0] map_base, map_addr;
  logic [15:0] tile_addr;
  logic        fill_ok;

  // Map address: window or background tile map
  always_comb begin
    win_sel = cfg_i.mode_flags[MODE_WIN_EN]
              && ({3'b000, cfg_i.window_x} <= {col_q, 3'b000})
              && (cfg_i.window_y <= in_i.line_y);
    if (win_sel) begin
      map_base = cfg_i.mode_flags[MODE_WIN_MAP] ? MAP_BASE_HI : MAP_BASE_LO;
      map_col  = col_q[4:0] - cfg_i.window_x[7:3];
      map_row  = in_i.window_line[7:3];
    end else begin
      map_base = cfg_i.mode_flags[MODE_BG_MAP] ? MAP_BASE_HI : MAP_BASE_LO;
      map_col  = col_q[4:0] + cfg_i.scroll_x[7:3];
      map_row  = in_i.line_y[7:3] + cfg_i.scroll_y[7:3];
    end
    map_addr = map_base + {6'b0, map_row, map_col};
  end

  // Tile row address from the returned index, signed or unsigned addressing
  always_comb begin
    if (cfg_i.mode_flags[MODE_UNS_TILES]) begin
      tile_addr = TILE_BASE_UNS + {4'b0, in_i.read_data, 4'b0};
    end else begin
      tile_addr = TILE_BASE_SGN + {{4{in_i.read_data[7]}}, in_i.read_data, 4'b0};
    end
    tile_addr = tile_addr + {12'b0, in_i.line_y[2:0], 1'b0};
  end

  assign fill_ok = 32'(in_i.fifo_fill) < 32'(FIFO_LIMIT);

  // Next state and result descriptor
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    low_d   = low_q;
    high_d  = high_q;
    burst_o = '{valid: 1'b0, pixels: 1'b0, kind: KIND_READ, addr: '0,
                low: '0, high: '0};
    if (in_i.req_type) begin
      // Line reset: restart the line and flush downstream
      col_d        = '0;
      phase_d      = PH_MAP;
      burst_o.valid = 1'b1;
      burst_o.kind  = KIND_FLUSH;
    end else begin
      unique case (phase_q)
        PH_INDEX: begin
          row_d         = tile_addr;
          phase_d       = PH_LOW;
          burst_o.valid = 1'b1;
          burst_o.addr  = tile_addr;
        end
        PH_LOW: begin
          low_d         = in_i.read_data;
          phase_d       = PH_HIGH;
          burst_o.valid = 1'b1;
          burst_o.addr  = row_q + 16'd1;
        end
        PH_HIGH: begin
          high_d  = in_i.read_data;
          col_d   = col_q + 8'd1;
          phase_d = PH_PUSH;
        end
        PH_PUSH: begin
          if (fill_ok) begin
            phase_d        = PH_MAP;
            burst_o.valid  = 1'b1;
            burst_o.pixels = 1'b1;
            burst_o.kind   = KIND_PIXEL;
            if (cfg_i.mode_flags[MODE_BG_EN]) begin
              burst_o.low  = low_q;
              burst_o.high = high_q;
            end
          end
        end
        default: begin
          phase_d       = PH_INDEX;
          burst_o.valid = 1'b1;
          burst_o.addr  = map_addr;
        end
      endcase
    end
    if (!accept_i) begin
      burst_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAP;
      col_q   <= '0;
      row_q   <= '0;
      low_q   <= '0;
      high_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      row_q   <= row_d;
      low_q   <= low_d;
      high_q  <= high_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/bgwtf_out.sv -----
// ----------------------------------------------------------------------------
// bgwtf_out
// Result register: holds one result and plays an eight-pixel burst beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bgwtf_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bgwtf_pkg::burst_t burst_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bgwtf_pkg::out_t        out_data_o
);
  import bgwtf_pkg::*;

  logic                 valid_q, valid_d;
  logic                 pix_q, pix_d;
  kind_e                kind_q, kind_d;
  logic [15:0]          addr_q, addr_d;
  logic [7:0]           low_q, low_d;
  logic [7:0]           high_q, high_d;
  logic [PIX_CNT_W-1:0] cnt_q, cnt_d;

  logic take;
  logic final_beat;

  assign take       = valid_q && out_ready_i;
  assign final_beat = !pix_q || (cnt_q == PIX_CNT_W'(TILE_PIXELS - 1));
  // Slot opens as the last beat of the current result leaves
  assign free_o     = !valid_q || (out_ready_i && final_beat);

  // Load a new result or advance through the burst
  always_comb begin
    valid_d = valid_q;
    pix_d   = pix_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    low_d   = low_q;
    high_d  = high_q;
    cnt_d   = cnt_q;
    if (burst_i.valid) begin
      valid_d = 1'b1;
      pix_d   = burst_i.pixels;
      kind_d  = burst_i.kind;
      addr_d  = burst_i.addr;
      low_d   = burst_i.low;
      high_d  = burst_i.high;
      cnt_d   = '0;
    end else if (take) begin
      if (final_beat) begin
        valid_d = 1'b0;
        cnt_d   = '0;
      end else begin
        low_d  = {low_q[6:0], 1'b0};
        high_d = {high_q[6:0], 1'b0};
        cnt_d  = cnt_q + PIX_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pix_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pix_q   <= pix_d;
      cnt_q   <= cnt_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    low_q  <= low_d;
    high_q <= high_d;
  end

  // Current beat, MSB pixel first
  assign out_valid_o            = valid_q;
  assign out_data_o.out_kind    = kind_q;
  assign out_data_o.mem_addr    = pix_q ? 16'h0000 : addr_q;
  assign out_data_o.pixel_color = pix_q ? {high_q[7], low_q[7]} : 2'b00;
  assign out_data_o.last        = final_beat;

  `ASSERT_NEVER(a_load_over_busy, burst_i.valid && !free_o,
                "result loaded while the previous one is still pending")
  `ASSERT_NEVER(a_cnt_single, valid_q && !pix_q && (cnt_q != '0),
                "beat counter running on a single-beat result")
  `ASSERT_CLK(a_drain, take && final_beat && !burst_i.valid |=> !valid_q,
              "result register not emptied after its last beat")

endmodule

`default_nettype wire

// ----- design/bg_window_tile_fetcher_core.sv -----
// ----------------------------------------------------------------------------
// bg_window_tile_fetcher_core
// Background and window tile fetcher of a tiled display controller.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one beat per fetch step (or a line reset), carrying the byte
//                 read for the previous request and the line/FIFO status.
//   out channel : read requests, pixel pushes and flushes, one per beat; the
//                 last beat caused by an input beat has last set.
//   cfg channel : register writes, always ready, applied at the clock edge.
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while each causes at most one result
//   and the receiver is ready. A push phase produces eight pixel beats, so the
//   input waits while the result register plays out the burst.
// A fetch step that causes no result (high byte capture, FIFO full) is
//   absorbed with nothing on the out channel.
// Reset: sequencer returns to the map request phase with column zero, all
//   configuration registers clear, no result pending.
// Receiver stall: the result register holds its beat; a new input beat is
//   taken only in the cycle the last pending beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module bg_window_tile_fetcher_core #(
  parameter int FIFO_LIMIT = bgwtf_pkg::FIFO_LIMIT_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bgwtf_pkg::in_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output bgwtf_pkg::out_t     out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [2:0]     cfg_index_i,
  input  wire logic [7:0]     cfg_data_i
);
  import bgwtf_pkg::*;

  cfg_t   cfg;
  burst_t burst;
  logic   out_free;
  logic   in_accept;

  assign in_ready_o = out_free;
  assign in_accept  = in_valid_i && out_free;

  bgwtf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bgwtf_seq #(
    .FIFO_LIMIT (FIFO_LIMIT)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .in_i     (in_data_i),
    .cfg_i    (cfg),
    .burst_o  (burst)
  );

  bgwtf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .burst_i     (burst),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression bench for the background/window tile fetcher. A queue of beats
// and register writes, built up front, feeds a clocked driver; a clocked
// monitor predicts every result beat from the accepted inputs and checks the
// out channel against it in order. Directed cases cover address extremes,
// signed and unsigned tiles, window selection, FIFO stalls and line resets;
// random tiles, broken sequences and noise follow, and a long line at the end
// walks the tile column past 32 into the window.
// ----------------------------------------------------------------------------
module tb;
  import bgwtf_pkg::*;

  localparam int SETTLE_CYCLES = 4;   // quiet time before a register write
  localparam int DRAIN_CYCLES  = 20;  // watch for stray beats at the end
  localparam int RANDOM_BEATS  = 175; // directed plus random beats

  // one queued stimulus entry: either an input beat or a register write
  typedef struct {
    bit         is_write;
    bit         calm;
    cfg_idx_e   reg_idx;
    logic [7:0] reg_val;
    in_t        beat;
  } stim_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_e   cfg_index = CFG_MODE;
  logic [7:0] cfg_data = '0;

  stim_t stim_q[$];
  out_t  due_beats[$];
  int    beat_count = 0;
  int    fail_count = 0;
  bit    tail_calm = 1'b0;

  // predictor state, reset values
  cfg_t        regs = '0;
  phase_e      fetch_ph = PH_MAP;
  logic [7:0]  tile_col = '0;
  logic [15:0] row_addr = '0;
  logic [7:0]  low_pl = '0;
  logic [7:0]  high_pl = '0;

  // driver state
  int    gap_left, stall_left, quiet;
  bit    idle_on, calm_now, beat_taken;
  stim_t drv_op;
  out_t  want;

  bg_window_tile_fetcher_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction: one fetch step per accepted beat
  // --------------------------------------------------------------------------
  function automatic void fetch_step(input in_t b);
    out_t        r;
    logic        win;
    logic [15:0] base;
    logic [4:0]  mcol, mrow;
    int          px;
    r = '0;
    r.last = 1'b1;
    if (b.req_type) begin
      tile_col = '0;
      fetch_ph = PH_MAP;
      r.out_kind = KIND_FLUSH;
      due_beats.push_back(r);
      return;
    end
    case (fetch_ph)
      PH_INDEX: begin
        if (regs.mode_flags[MODE_UNS_TILES]) begin
          row_addr = TILE_BASE_UNS + {4'b0, b.read_data, 4'b0};
        end else begin
          row_addr = TILE_BASE_SGN + {{4{b.read_data[7]}}, b.read_data, 4'b0};
        end
        row_addr = row_addr + {12'b0, b.line_y[2:0], 1'b0};
        fetch_ph = PH_LOW;
        r.out_kind = KIND_READ;
        r.mem_addr = row_addr;
        due_beats.push_back(r);
      end
      PH_LOW: begin
        low_pl = b.read_data;
        fetch_ph = PH_HIGH;
        r.out_kind = KIND_READ;
        r.mem_addr = row_addr + 16'd1;
        due_beats.push_back(r);
      end
      PH_HIGH: begin
        high_pl = b.read_data;
        tile_col = tile_col + 8'd1;
        fetch_ph = PH_PUSH;
      end
      PH_PUSH: begin
        // FIFO at or above the threshold: wait, nothing emitted
        if (b.fifo_fill < FIFO_LIMIT_DEF) begin
          for (px = 7; px >= 0; px--) begin
            r = '0;
            r.out_kind = KIND_PIXEL;
            if (regs.mode_flags[MODE_BG_EN]) r.pixel_color = {high_pl[px], low_pl[px]};
            r.last = (px == 0);
            due_beats.push_back(r);
          end
          fetch_ph = PH_MAP;
        end
      end
      default: begin
        // window test uses the full column * 8 product
        win = regs.mode_flags[MODE_WIN_EN] &&
              ({3'b0, regs.window_x} <= {tile_col, 3'b000}) &&
              (regs.window_y <= b.line_y);
        if (win) begin
          base = regs.mode_flags[MODE_WIN_MAP] ? MAP_BASE_HI : MAP_BASE_LO;
          mcol = tile_col[4:0] - regs.window_x[7:3];
          mrow = b.window_line[7:3];
        end else begin
          base = regs.mode_flags[MODE_BG_MAP] ? MAP_BASE_HI : MAP_BASE_LO;
          mcol = tile_col[4:0] + regs.scroll_x[7:3];
          mrow = b.line_y[7:3] + regs.scroll_y[7:3];
        end
        fetch_ph = PH_INDEX;
        r.out_kind = KIND_READ;
        r.mem_addr = base + {6'b0, mrow, mcol};
        due_beats.push_back(r);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void add_beat(input logic req, input logic [7:0] data,
                                   input logic [7:0] ly, input logic [7:0] wly,
                                   input logic [4:0] fill);
    stim_t s;
    s.is_write = 1'b0;
    s.reg_idx  = CFG_MODE;
    s.reg_val  = '0;
    s.calm = tail_calm;
    s.beat.req_type    = req;
    s.beat.read_data   = data;
    s.beat.line_y      = ly;
    s.beat.window_line = wly;
    s.beat.fifo_fill   = fill;
    stim_q.push_back(s);
    beat_count++;
  endfunction

  function automatic void add_write(input cfg_idx_e idx, input logic [7:0] val);
    stim_t s;
    s.beat     = '0;
    s.is_write = 1'b1;
    s.calm     = tail_calm;
    s.reg_idx  = idx;
    s.reg_val  = val;
    stim_q.push_back(s);
  endfunction

  function automatic void add_config(input logic [7:0] mode, input logic [7:0] sx,
                                     input logic [7:0] sy, input logic [7:0] wx,
                                     input logic [7:0] wy);
    add_write(CFG_MODE, mode);
    add_write(CFG_SCROLL_X, sx);
    add_write(CFG_SCROLL_Y, sy);
    add_write(CFG_WINDOW_X, wx);
    add_write(CFG_WINDOW_Y, wy);
  endfunction

  function automatic logic [7:0] mode_bits(input bit win_en, input bit uns,
                                           input bit win_hi, input bit bg_hi,
                                           input bit bg_en);
    logic [7:0] m;
    m = '0;
    m[MODE_WIN_EN]    = win_en;
    m[MODE_UNS_TILES] = uns;
    m[MODE_WIN_MAP]   = win_hi;
    m[MODE_BG_MAP]    = bg_hi;
    m[MODE_BG_EN]     = bg_en;
    return m;
  endfunction

  // random byte that often lands on an extreme
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one tile: map, index, low, high, optional FIFO-full stalls, push;
  // a line reset replaces the step numbered cut when cut < 5
  function automatic void add_tile(input int cut, input bit fast);
    logic [7:0] ly, wly;
    int         stalls, s, k;
    ly  = pick_byte();
    wly = pick_byte();
    stalls = fast ? 0 : $urandom_range(0, 2);
    for (s = 0; s < 5; s++) begin
      if (s == cut) begin
        add_beat(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        return;
      end
      if (s < 4) begin
        add_beat(1'b0, 8'($urandom_range(0, 255)), ly, wly,
                 fast ? 5'd0 : 5'($urandom_range(0, 31)));
      end else begin
        for (k = 0; k < stalls; k++) begin
          add_beat(1'b0, 8'($urandom_range(0, 255)), ly, wly,
                   5'($urandom_range(16, 31)));
        end
        add_beat(1'b0, 8'($urandom_range(0, 255)), ly, wly,
                 fast ? 5'd0 : 5'($urandom_range(0, 15)));
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: input beats, register writes and receiver stalls
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= CFG_MODE;
      cfg_data  <= '0;
      out_ready <= 1'b0;
      gap_left   = 0;
      stall_left = 0;
      quiet      = 0;
      idle_on    = 1'b1;
      calm_now   = 1'b0;
    end else begin
      beat_taken = 1'b0;
      if ($urandom_range(0, 59) == 0) idle_on = !idle_on;

      // input channel
      if (in_valid && !in_ready) begin
        // beat still pending, hold it
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0 && !stim_q[0].is_write) begin
        drv_op = stim_q.pop_front();
        in_valid <= 1'b1;
        in_data  <= drv_op.beat;
        beat_taken = 1'b1;
        calm_now   = drv_op.calm;
        if (!calm_now && idle_on && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 19);
        end
      end else begin
        in_valid <= 1'b0;
      end

      // register writes only once the fetcher has gone quiet
      if (cfg_valid && !cfg_ready) begin
        // write still pending
      end else if (!beat_taken && !in_valid && stim_q.size() != 0 &&
                   stim_q[0].is_write && due_beats.size() == 0 &&
                   quiet >= SETTLE_CYCLES && !(out_valid && out_ready)) begin
        drv_op = stim_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= drv_op.reg_idx;
        cfg_data  <= drv_op.reg_val;
        calm_now = drv_op.calm;
      end else begin
        cfg_valid <= 1'b0;
      end

      // receiver backpressure
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm_now && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else if (quiet < 255) begin
        quiet++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check leaving beats, then track writes and new inputs
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat kind %0d addr %h color %0d last %0b", $time,
                   out_data.out_kind, out_data.mem_addr, out_data.pixel_color,
                   out_data.last);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          if (out_data.out_kind !== want.out_kind || out_data.mem_addr !== want.mem_addr ||
              out_data.pixel_color !== want.pixel_color || out_data.last !== want.last) begin
            $display("%0t: beat mismatch, expected kind %0d addr %h color %0d last %0b",
                     $time, want.out_kind, want.mem_addr, want.pixel_color, want.last);
            $display("%0t:                actual kind %0d addr %h color %0d last %0b",
                     $time, out_data.out_kind, out_data.mem_addr, out_data.pixel_color,
                     out_data.last);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:     regs.mode_flags = cfg_data[4:0];
          CFG_SCROLL_X: regs.scroll_x   = cfg_data;
          CFG_SCROLL_Y: regs.scroll_y   = cfg_data;
          CFG_WINDOW_X: regs.window_x   = cfg_data;
          CFG_WINDOW_Y: regs.window_y   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) fetch_step(in_data);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int cfg_mark, pick, i;

    // unsigned tiles, maximum scroll, full FIFO stalls
    add_config(mode_bits(0, 1, 0, 0, 1), 8'hFF, 8'hFF, 8'h00, 8'h00);
    add_beat(1'b0, 8'h00, 8'hFF, 8'h00, 5'd0);   // map request
    add_beat(1'b0, 8'hFF, 8'hFF, 8'h00, 5'd0);   // top tile index
    add_beat(1'b0, 8'hA5, 8'hFF, 8'h00, 5'd0);   // low plane
    add_beat(1'b0, 8'h3C, 8'hFF, 8'h00, 5'd0);   // high plane
    add_beat(1'b0, 8'h00, 8'hFF, 8'h00, 5'd16);  // FIFO at threshold
    add_beat(1'b0, 8'h00, 8'hFF, 8'h00, 5'd31);  // fill at its maximum
    add_beat(1'b0, 8'h00, 8'hFF, 8'h00, 5'd15);  // push
    add_beat(1'b0, 8'hFF, 8'h00, 8'hFF, 5'd0);   // map with stale data
    add_beat(1'b1, 8'hFF, 8'hFF, 8'hFF, 5'd31);  // line reset mid-tile

    // signed tiles, window enabled but left edge out of reach
    add_config(mode_bits(1, 0, 1, 1, 1), 8'h00, 8'h00, 8'hFF, 8'h00);
    add_beat(1'b0, 8'h00, 8'h80, 8'h7F, 5'd16);
    add_beat(1'b0, 8'h80, 8'h07, 8'h00, 5'd0);   // most negative index
    add_beat(1'b0, 8'hFF, 8'h07, 8'h00, 5'd0);
    add_beat(1'b0, 8'h00, 8'h07, 8'h00, 5'd0);
    add_beat(1'b0, 8'hFF, 8'h07, 8'h00, 5'd0);   // push ignores data

    // window starts at this line
    add_write(CFG_WINDOW_X, 8'h00);
    add_write(CFG_WINDOW_Y, 8'h80);
    add_beat(1'b0, 8'h00, 8'h80, 8'hFF, 5'd0);
    add_beat(1'b0, 8'h7F, 8'h80, 8'hFF, 5'd0);   // most positive index
    add_beat(1'b0, 8'h00, 8'h80, 8'hFF, 5'd0);
    add_beat(1'b0, 8'hFF, 8'h80, 8'hFF, 5'd0);
    add_beat(1'b0, 8'h00, 8'h80, 8'hFF, 5'd0);

    // background disabled: pushes carry color zero
    add_write(CFG_MODE, mode_bits(0, 0, 0, 0, 0));
    add_beat(1'b0, 8'h00, 8'h7F, 8'h00, 5'd0);
    add_beat(1'b0, 8'h00, 8'h7F, 8'h00, 5'd0);
    add_beat(1'b0, 8'hFF, 8'h7F, 8'h00, 5'd0);
    add_beat(1'b0, 8'hFF, 8'h7F, 8'h00, 5'd0);
    add_beat(1'b0, 8'h00, 8'h7F, 8'h00, 5'd0);
    add_beat(1'b1, 8'h00, 8'h00, 8'h00, 5'd0);

    // random part: mostly whole tiles, some broken ones and noise
    add_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    cfg_mark = beat_count;
    while (beat_count < RANDOM_BEATS) begin
      if (beat_count - cfg_mark >= 50) begin
        if ($urandom_range(0, 3) == 0) begin
          add_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        end else begin
          add_config(pick_byte(), pick_byte(), pick_byte(), pick_byte(), pick_byte());
        end
        cfg_mark = beat_count;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        add_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 5'($urandom_range(0, 31)));
        if ($urandom_range(0, 1) == 0) add_beat(1'b1, 8'h00, 8'h00, 8'h00, 5'd0);
      end else if (pick == 1) begin
        add_beat(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
      end else if (pick == 2) begin
        add_tile($urandom_range(0, 4), 1'b0);
      end else begin
        add_tile(5, 1'b0);
      end
    end

    // one long line without idling: column runs past 32 into the window
    tail_calm = 1'b1;
    add_config(mode_bits(1, 1, 1, 0, 1), 8'h08, 8'hF8, 8'hF8, 8'h00);
    add_beat(1'b1, 8'h00, 8'h00, 8'h00, 5'd0);
    for (i = 0; i < 40; i++) add_tile(5, 1'b1);
    add_beat(1'b1, 8'hFF, 8'hFF, 8'hFF, 5'd0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid || cfg_valid || due_beats.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("bg_window_tile_fetcher_core regression: pass");
    end else begin
      $display("bg_window_tile_fetcher_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("bg_window_tile_fetcher_core regression: fail");
    $finish;
  end

endmodule
